// ===== rtl/point_in_quad_hull_classify_top_defines.svh =====
// Assertion macros for the quad hull classifier checker.
// Used by pqh_checker.sv only.
`ifndef POINT_IN_QUAD_HULL_CLASSIFY_TOP_DEFINES_SVH
`define POINT_IN_QUAD_HULL_CLASSIFY_TOP_DEFINES_SVH

// Same-cycle implication, reset masks the check.
`define PQH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pqh check failed");

// Next-cycle implication, reset masks the check.
`define PQH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pqh check failed");

`endif

// ===== rtl/pqh_pkg.sv =====
// Shared types, index tables and helpers for the quad hull classifier.
// No dependencies.
package pqh_pkg;

    // Pairs of hull points, ordered (0,1) (0,2) (0,3) (1,2) (1,3) (2,3).
    localparam int NUM_PAIRS = 6;
    localparam int PAIR_A [NUM_PAIRS] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_B [NUM_PAIRS] = '{1, 2, 3, 2, 3, 3};

    // Triples named by the point they leave out, members in ascending order.
    localparam int TRI_A [4] = '{1, 0, 0, 0};
    localparam int TRI_B [4] = '{2, 2, 1, 1};
    localparam int TRI_C [4] = '{3, 3, 3, 2};

    localparam logic [1:0] SGN_ZERO = 2'b00;
    localparam logic [1:0] SGN_POS  = 2'b01;
    localparam logic [1:0] SGN_NEG  = 2'b11;

    typedef enum logic [1:0] {
        CLS_OUTSIDE  = 2'd0,
        CLS_BOUNDARY = 2'd1,
        CLS_INSIDE   = 2'd2
    } t_class;

    // Orientation signs and compare flags handed from the arithmetic to the decision.
    typedef struct packed {
        logic [3:0][1:0] tri_s;   // orientation of each triple, by left-out point
        logic [5:0][1:0] oq_s;    // orientation of q against each pair, low index first
        logic            box_out; // q outside bounding box
        logic [5:0]      wx;      // q.x within the pair's x range
        logic [5:0]      wy;      // q.y within the pair's y range
        logic [3:0]      peq;     // q equals point
        logic [3:0][2:0] seg;     // extreme pair of each triple if it is flat
        logic [3:0]      pt_only; // flat triple collapses to one point
    } t_geo;

    function automatic int pair_idx(input int i, input int j);
        int lo, hi;
        lo = (i < j) ? i : j;
        hi = (i < j) ? j : i;
        if (lo == 0) return hi - 1;
        else if (lo == 1) return hi + 1;
        else return 5;
    endfunction

    function automatic logic [1:0] sgn_neg(input logic [1:0] s);
        return 2'(-s);
    endfunction

endpackage

// ===== rtl/point_in_quad_hull_classify_top.sv =====
// Channel   Dir  Content (low bit first)
// s_*       in   query_x, query_y, first_x/y .. fourth_x/y, COORD_WIDTH bits each
// m_*       out  hull_class in bits [1:0]
//
// One item per cycle while m_tready does not stall the output; an item's result passes
// through the difference, product and sign stages, then the output register.
// Reset (i_rst_n low, synchronous) clears the valid flags only; the data registers are not reset.
// A stall on m_tready freezes every stage and drops s_tready in the same cycle.
// Top level of the quad hull classifier; uses pqh_pkg, pqh_orient, pqh_decide.
module point_in_quad_hull_classify_top #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // query_x, query_y, first_x, first_y, second_x, second_y,
    // third_x, third_y, fourth_x, fourth_y, then zero fill
    input  logic [((10*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // hull_class, then zero fill
    output logic [7:0]                            m_tdata
);
    import pqh_pkg::*;

    localparam int W = COORD_WIDTH;

    logic                r_vld [4];
    logic [1:0]          r_class;
    logic                adv;
    logic signed [W-1:0] qx, qy;
    logic signed [W-1:0] px [4];
    logic signed [W-1:0] py [4];
    t_geo                geo;
    t_class              cls;

    assign adv      = !r_vld[3] || m_tready;
    assign s_tready = adv;

    assign qx = s_tdata[W-1:0];
    assign qy = s_tdata[2*W-1:W];
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            px[i] = s_tdata[(2*i+2)*W +: W];
            py[i] = s_tdata[(2*i+3)*W +: W];
        end
    end

    pqh_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_qx  (qx),
        .i_qy  (qy),
        .i_px  (px),
        .i_py  (py),
        .o_geo (geo)
    );

    pqh_decide u_decide (
        .i_geo   (geo),
        .o_class (cls)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 4; s++) r_vld[s] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= s_tvalid;
            for (int s = 1; s < 4; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_class <= cls;
        end
    end

    assign m_tvalid = r_vld[3];
    assign m_tdata  = {6'b0, r_class};

endmodule

// ===== rtl/pqh_orient.sv =====
// Three-stage arithmetic: coordinate differences, products, cross-product signs
// and range compares. Depends on pqh_pkg.
module pqh_orient #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_qx,
    input  logic signed [COORD_WIDTH-1:0] i_qy,
    input  logic signed [COORD_WIDTH-1:0] i_px [4],
    input  logic signed [COORD_WIDTH-1:0] i_py [4],
    output pqh_pkg::t_geo                 o_geo
);
    import pqh_pkg::*;

    localparam int W = COORD_WIDTH;
    localparam int D = W + 1;
    localparam int P = 2 * D;

    // stage 0: differences
    logic signed [D-1:0] r_dx [NUM_PAIRS];
    logic signed [D-1:0] r_dy [NUM_PAIRS];
    logic signed [D-1:0] r_ex [4];
    logic signed [D-1:0] r_ey [4];
    logic signed [W-1:0] r0_qx, r0_qy;
    logic signed [W-1:0] r0_px [4];
    logic signed [W-1:0] r0_py [4];
    // stage 1: products
    logic signed [P-1:0] r_tp1 [4];
    logic signed [P-1:0] r_tp2 [4];
    logic signed [P-1:0] r_qp1 [NUM_PAIRS];
    logic signed [P-1:0] r_qp2 [NUM_PAIRS];
    logic signed [W-1:0] r1_qx, r1_qy;
    logic signed [W-1:0] r1_px [4];
    logic signed [W-1:0] r1_py [4];
    // stage 2: signs and flags
    t_geo r_geo;
    t_geo n_geo;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_PAIRS; k++) begin
                r_dx[k] <= D'(i_px[PAIR_B[k]]) - D'(i_px[PAIR_A[k]]);
                r_dy[k] <= D'(i_py[PAIR_B[k]]) - D'(i_py[PAIR_A[k]]);
            end
            for (int i = 0; i < 4; i++) begin
                r_ex[i]  <= D'(i_qx) - D'(i_px[i]);
                r_ey[i]  <= D'(i_qy) - D'(i_py[i]);
                r0_px[i] <= i_px[i];
                r0_py[i] <= i_py[i];
            end
            r0_qx <= i_qx;
            r0_qy <= i_qy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int m = 0; m < 4; m++) begin
                r_tp1[m] <= r_dx[pair_idx(TRI_A[m], TRI_B[m])]
                          * r_dy[pair_idx(TRI_A[m], TRI_C[m])];
                r_tp2[m] <= r_dy[pair_idx(TRI_A[m], TRI_B[m])]
                          * r_dx[pair_idx(TRI_A[m], TRI_C[m])];
                r1_px[m] <= r0_px[m];
                r1_py[m] <= r0_py[m];
            end
            for (int k = 0; k < NUM_PAIRS; k++) begin
                r_qp1[k] <= r_dx[k] * r_ey[PAIR_A[k]];
                r_qp2[k] <= r_dy[k] * r_ex[PAIR_A[k]];
            end
            r1_qx <= r0_qx;
            r1_qy <= r0_qy;
        end
    end

    always_comb begin
        logic signed [P:0]   cr;
        logic signed [W-1:0] xmin, xmax, ymin, ymax;
        logic                use_x;
        int                  ids [3];
        int                  u, v;
        n_geo = '0;
        for (int m = 0; m < 4; m++) begin
            cr = (P+1)'(r_tp1[m]) - (P+1)'(r_tp2[m]);
            n_geo.tri_s[m] = (cr == '0) ? SGN_ZERO : (cr[P] ? SGN_NEG : SGN_POS);
        end
        for (int k = 0; k < NUM_PAIRS; k++) begin
            cr = (P+1)'(r_qp1[k]) - (P+1)'(r_qp2[k]);
            n_geo.oq_s[k] = (cr == '0) ? SGN_ZERO : (cr[P] ? SGN_NEG : SGN_POS);
            n_geo.wx[k] = (r1_px[PAIR_A[k]] <= r1_qx && r1_qx <= r1_px[PAIR_B[k]])
                       || (r1_px[PAIR_B[k]] <= r1_qx && r1_qx <= r1_px[PAIR_A[k]]);
            n_geo.wy[k] = (r1_py[PAIR_A[k]] <= r1_qy && r1_qy <= r1_py[PAIR_B[k]])
                       || (r1_py[PAIR_B[k]] <= r1_qy && r1_qy <= r1_py[PAIR_A[k]]);
        end
        // bounding box of all four points
        xmin = r1_px[0]; xmax = r1_px[0]; ymin = r1_py[0]; ymax = r1_py[0];
        for (int i = 1; i < 4; i++) begin
            if (r1_px[i] < xmin) xmin = r1_px[i];
            if (r1_px[i] > xmax) xmax = r1_px[i];
            if (r1_py[i] < ymin) ymin = r1_py[i];
            if (r1_py[i] > ymax) ymax = r1_py[i];
        end
        n_geo.box_out = r1_qx < xmin || r1_qx > xmax || r1_qy < ymin || r1_qy > ymax;
        for (int i = 0; i < 4; i++) begin
            n_geo.peq[i] = (r1_qx == r1_px[i]) && (r1_qy == r1_py[i]);
        end
        // extreme pair of each triple along its dominant axis
        for (int m = 0; m < 4; m++) begin
            ids[0] = TRI_A[m]; ids[1] = TRI_B[m]; ids[2] = TRI_C[m];
            xmin = r1_px[ids[0]]; xmax = xmin; ymin = r1_py[ids[0]]; ymax = ymin;
            for (int t = 1; t < 3; t++) begin
                if (r1_px[ids[t]] < xmin) xmin = r1_px[ids[t]];
                if (r1_px[ids[t]] > xmax) xmax = r1_px[ids[t]];
                if (r1_py[ids[t]] < ymin) ymin = r1_py[ids[t]];
                if (r1_py[ids[t]] > ymax) ymax = r1_py[ids[t]];
            end
            use_x = (D'(xmax) - D'(xmin)) >= (D'(ymax) - D'(ymin));
            u = ids[0];
            v = ids[0];
            for (int t = 1; t < 3; t++) begin
                if (use_x) begin
                    if (r1_px[ids[t]] < r1_px[u]) u = ids[t];
                    if (r1_px[ids[t]] > r1_px[v]) v = ids[t];
                end else begin
                    if (r1_py[ids[t]] < r1_py[u]) u = ids[t];
                    if (r1_py[ids[t]] > r1_py[v]) v = ids[t];
                end
            end
            n_geo.pt_only[m] = (u == v);
            n_geo.seg[m]     = 3'(pair_idx(u, v));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_geo <= n_geo;
        end
    end

    assign o_geo = r_geo;

endmodule

// ===== rtl/pqh_decide.sv =====
// Hull membership and boundary decision from orientation signs and flags.
// Depends on pqh_pkg.
module pqh_decide (
    input  pqh_pkg::t_geo   i_geo,
    output pqh_pkg::t_class o_class
);
    import pqh_pkg::*;

    function automatic logic [1:0] ori(input t_geo g, input int i, input int j, input int k);
        int inv;
        inv = int'(i > j) + int'(i > k) + int'(j > k);
        return inv[0] ? sgn_neg(g.tri_s[6 - i - j - k]) : g.tri_s[6 - i - j - k];
    endfunction

    function automatic logic [1:0] oq(input t_geo g, input int i, input int j);
        return (i < j) ? g.oq_s[pair_idx(i, j)] : sgn_neg(g.oq_s[pair_idx(i, j)]);
    endfunction

    function automatic logic on_seg(input t_geo g, input int k);
        return g.oq_s[k] == SGN_ZERO && g.wx[k] && g.wy[k];
    endfunction

    always_comb begin
        logic [1:0] s0, s1, s2;
        logic [3:0] in_tri;
        logic       flat, edge_hit;
        int         o0, o1;
        s0 = SGN_ZERO;
        s1 = SGN_ZERO;
        s2 = SGN_ZERO;
        o0 = -1;
        o1 = -1;
        for (int m = 0; m < 4; m++) begin
            if (i_geo.tri_s[m] == SGN_ZERO) begin
                in_tri[m] = i_geo.pt_only[m] ? i_geo.peq[TRI_A[m]]
                                             : on_seg(i_geo, int'(i_geo.seg[m]));
            end else begin
                s0 = oq(i_geo, TRI_A[m], TRI_B[m]);
                s1 = oq(i_geo, TRI_B[m], TRI_C[m]);
                s2 = oq(i_geo, TRI_C[m], TRI_A[m]);
                in_tri[m] = (s0 != SGN_NEG && s1 != SGN_NEG && s2 != SGN_NEG)
                         || (s0 != SGN_POS && s1 != SGN_POS && s2 != SGN_POS);
            end
        end
        flat = (i_geo.tri_s == '0);
        // boundary when q sits on a pair that has no points strictly on both sides
        edge_hit = 1'b0;
        for (int k = 0; k < NUM_PAIRS; k++) begin
            o0 = -1;
            o1 = -1;
            for (int t = 0; t < 4; t++) begin
                if (t != PAIR_A[k] && t != PAIR_B[k]) begin
                    if (o0 < 0) o0 = t;
                    else o1 = t;
                end
            end
            s1 = ori(i_geo, PAIR_A[k], PAIR_B[k], o0);
            s2 = ori(i_geo, PAIR_A[k], PAIR_B[k], o1);
            if (!((s1 == SGN_POS && s2 == SGN_NEG) || (s1 == SGN_NEG && s2 == SGN_POS))
                && on_seg(i_geo, k)) begin
                edge_hit = 1'b1;
            end
        end
        if (i_geo.box_out || in_tri == '0) begin
            o_class = CLS_OUTSIDE;
        end else if (flat || edge_hit) begin
            o_class = CLS_BOUNDARY;
        end else begin
            o_class = CLS_INSIDE;
        end
    end

endmodule

// ===== rtl/pqh_checker.sv =====
// Port-level checks for the quad hull classifier, bound to the top level.
// Depends on point_in_quad_hull_classify_top_defines.svh.
`include "point_in_quad_hull_classify_top_defines.svh"

module pqh_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    `PQH_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `PQH_ASSERT_NOW(a_code, i_clk, i_rst_n, m_tvalid, m_tdata[1:0] != 2'd3 && m_tdata[7:2] == 6'd0)
    `PQH_ASSERT_NOW(a_ready, i_clk, i_rst_n, 1'b1, s_tready == (!m_tvalid || m_tready))
    `PQH_ASSERT_NOW(a_fill, i_clk, i_rst_n, !m_tvalid, s_tready)
endmodule

bind point_in_quad_hull_classify_top pqh_checker u_pqh_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/tb_point_in_quad_hull_classify_top.sv =====
// Testbench for point_in_quad_hull_classify_top: random and directed point sets,
// class predicted in the bench and checked per item. Depends on pqh_pkg and the RTL.
`timescale 1ns / 100ps

module tb_point_in_quad_hull_classify_top;
    import pqh_pkg::*;

    localparam int CW = 16;
    localparam int DW = ((10 * CW + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [DW-1:0] s_tdata;   // query_x, query_y, first_x/y .. fourth_x/y
    logic          m_tvalid;
    logic          m_tready;
    logic [7:0]    m_tdata;   // hull_class, then zero fill

    t_class expected_class_q[$];
    int     mismatch_cnt;
    int     cycle_cnt;
    logic   item_taken;
    bit     sender_gaps;
    bit     receiver_gaps;
    bit     hold_request;
    int     hold_left;

    // predictor working copy of the current point set
    longint hx[4], hy[4], qx, qy;

    point_in_quad_hull_classify_top #(.COORD_WIDTH(CW)) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic int cross_sign(longint ax, longint ay, longint bx, longint by,
                                      longint cx, longint cy);
        longint d;
        d = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
        return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
    endfunction

    function automatic bit in_span(longint v, longint a, longint b);
        return (a <= b) ? (a <= v && v <= b) : (b <= v && v <= a);
    endfunction

    function bit query_on_pair(int u, int v);
        if (cross_sign(hx[u], hy[u], hx[v], hy[v], qx, qy) != 0)
            return 1'b0;
        return in_span(qx, hx[u], hx[v]) && in_span(qy, hy[u], hy[v]);
    endfunction

    function bit query_in_triple(int a, int b, int c);
        int     ids[3];
        longint xmin, xmax, ymin, ymax;
        int     u, v, k, s0, s1, s2;
        bit     along_x;
        ids[0] = a; ids[1] = b; ids[2] = c;
        if (cross_sign(hx[a], hy[a], hx[b], hy[b], hx[c], hy[c]) == 0) begin
            xmin = hx[a]; xmax = hx[a]; ymin = hy[a]; ymax = hy[a];
            for (int t = 1; t < 3; t++) begin
                k = ids[t];
                if (hx[k] < xmin) xmin = hx[k];
                if (hx[k] > xmax) xmax = hx[k];
                if (hy[k] < ymin) ymin = hy[k];
                if (hy[k] > ymax) ymax = hy[k];
            end
            along_x = (xmax - xmin) >= (ymax - ymin);
            u = a;
            v = a;
            for (int t = 1; t < 3; t++) begin
                k = ids[t];
                if (along_x) begin
                    if (hx[k] < hx[u]) u = k;
                    if (hx[k] > hx[v]) v = k;
                end else begin
                    if (hy[k] < hy[u]) u = k;
                    if (hy[k] > hy[v]) v = k;
                end
            end
            if (u == v)
                return qx == hx[u] && qy == hy[u];
            return query_on_pair(u, v);
        end
        s0 = cross_sign(hx[a], hy[a], hx[b], hy[b], qx, qy);
        s1 = cross_sign(hx[b], hy[b], hx[c], hy[c], qx, qy);
        s2 = cross_sign(hx[c], hy[c], hx[a], hy[a], qx, qy);
        return (s0 >= 0 && s1 >= 0 && s2 >= 0) || (s0 <= 0 && s1 <= 0 && s2 <= 0);
    endfunction

    function t_class classify_point_set(logic [DW-1:0] d);
        longint xmin, xmax, ymin, ymax;
        int     o[2], n, s1, s2;
        bit     flat;
        qx = longint'($signed(d[0 +: CW]));
        qy = longint'($signed(d[CW +: CW]));
        for (int i = 0; i < 4; i++) begin
            hx[i] = longint'($signed(d[(2 + 2 * i) * CW +: CW]));
            hy[i] = longint'($signed(d[(3 + 2 * i) * CW +: CW]));
        end
        xmin = hx[0]; xmax = hx[0]; ymin = hy[0]; ymax = hy[0];
        for (int i = 1; i < 4; i++) begin
            if (hx[i] < xmin) xmin = hx[i];
            if (hx[i] > xmax) xmax = hx[i];
            if (hy[i] < ymin) ymin = hy[i];
            if (hy[i] > ymax) ymax = hy[i];
        end
        if (qx < xmin || qx > xmax || qy < ymin || qy > ymax)
            return CLS_OUTSIDE;
        if (!(query_in_triple(0, 1, 2) || query_in_triple(0, 1, 3) ||
              query_in_triple(0, 2, 3) || query_in_triple(1, 2, 3)))
            return CLS_OUTSIDE;
        flat = cross_sign(hx[0], hy[0], hx[1], hy[1], hx[2], hy[2]) == 0 &&
               cross_sign(hx[0], hy[0], hx[1], hy[1], hx[3], hy[3]) == 0 &&
               cross_sign(hx[0], hy[0], hx[2], hy[2], hx[3], hy[3]) == 0 &&
               cross_sign(hx[1], hy[1], hx[2], hy[2], hx[3], hy[3]) == 0;
        if (flat)
            return CLS_BOUNDARY;
        for (int i = 0; i < 4; i++) begin
            for (int j = i + 1; j < 4; j++) begin
                n = 0;
                for (int k = 0; k < 4; k++)
                    if (k != i && k != j) begin
                        o[n] = k;
                        n++;
                    end
                s1 = cross_sign(hx[i], hy[i], hx[j], hy[j], hx[o[0]], hy[o[0]]);
                s2 = cross_sign(hx[i], hy[i], hx[j], hy[j], hx[o[1]], hy[o[1]]);
                // skip diagonals: the other two points straddle the pair
                if (!((s1 > 0 && s2 < 0) || (s1 < 0 && s2 > 0)) && query_on_pair(i, j))
                    return CLS_BOUNDARY;
            end
        end
        return CLS_INSIDE;
    endfunction

    // input monitor and result checker, both at the rising edge
    always @(posedge i_clk) begin
        item_taken <= i_rst_n && s_tvalid && s_tready;
        if (i_rst_n && s_tvalid && s_tready)
            expected_class_q.push_back(classify_point_set(s_tdata));
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_class_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result: class %0d", m_tdata[1:0]);
            end else begin
                t_class want;
                want = expected_class_q.pop_front();
                if (m_tdata[1:0] !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("class mismatch: expected %0d, actual %0d",
                                 want, m_tdata[1:0]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left = 300;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !receiver_gaps || ($urandom_range(99) >= 29);
        end
    end

    task automatic send_coords(input int c0, c1, c2, c3, c4, c5, c6, c7, c8, c9);
        logic [DW-1:0] d;
        int            c[10];
        c = '{c0, c1, c2, c3, c4, c5, c6, c7, c8, c9};
        d = '0;
        for (int i = 0; i < 10; i++)
            d[i * CW +: CW] = c[i][CW-1:0];
        // idle at random, each further idle step with the same odds
        while (sender_gaps && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(negedge i_clk); while (!item_taken);
    endtask

    function automatic int rnd_coord(int span);
        if (span == 0)
            return $signed($urandom_range(65535, 0)) - 32768;
        return $signed($urandom_range(2 * span, 0)) - span;
    endfunction

    task automatic test_directed();
        // 10 by 10 square: inside, edge, vertex, box outside
        send_coords(5, 5, 0, 0, 10, 0, 10, 10, 0, 10);
        send_coords(5, 0, 0, 0, 10, 0, 10, 10, 0, 10);
        send_coords(10, 10, 0, 0, 10, 0, 10, 10, 0, 10);
        send_coords(11, 5, 0, 0, 10, 0, 10, 10, 0, 10);
        // triangle with a point on top of it; q in the box but off the hull
        send_coords(9, 9, 0, 0, 10, 0, 0, 10, 2, 2);
        send_coords(2, 2, 0, 0, 10, 0, 0, 10, 2, 2);
        // crossing diagonals: q on a diagonal is inside
        send_coords(5, 5, 0, 0, 10, 10, 10, 0, 0, 10);
        // all points coincident
        send_coords(3, -4, 3, -4, 3, -4, 3, -4, 3, -4);
        send_coords(3, -3, 3, -4, 3, -4, 3, -4, 3, -4);
        // collinear hulls along the diagonal and along y, then q off a diagonal and an x hull
        send_coords(2, 2, 0, 0, 4, 4, 1, 1, 3, 3);
        send_coords(0, 3, 0, -5, 0, 7, 0, 1, 0, 2);
        send_coords(2, 3, 0, 0, 4, 4, 1, 1, 3, 3);
        send_coords(0, 1, -2, 0, 6, 0, 2, 0, 2, 0);
        // duplicated points forming a triangle
        send_coords(1, 1, 0, 0, 0, 0, 4, 0, 0, 4);
        send_coords(2, 2, 0, 0, 0, 0, 4, 0, 0, 4);
        // coordinate extremes
        send_coords(0, 0, -32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767);
        send_coords(-32768, -32768, -32768, -32768, 32767, -32768, 32767, 32767,
                    -32768, 32767);
        send_coords(32767, 0, -32768, -32768, 32767, -32768, 32767, 32767,
                    -32768, 32767);
        send_coords(-32768, 32767, 32767, -32768, -32768, 32767, 0, 0, 100, 100);
        send_coords(-1, -1, -32768, 32767, 32767, -32768, 32767, 32767, 32767, 32767);
        send_coords(32767, 32767, 0, 0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random_sets(input int count);
        int c[10];
        int span, ax, ay, dx, dy;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(4))
                0: span = 0;
                1: span = 40;
                default: span = 6;
            endcase
            for (int i = 0; i < 10; i++)
                c[i] = rnd_coord(span);
            case ($urandom_range(5))
                0: begin
                    // collinear hull, q on or near the line
                    ax = rnd_coord(8); ay = rnd_coord(8);
                    dx = rnd_coord(3); dy = rnd_coord(3);
                    for (int i = 1; i < 5; i++) begin
                        c[2 * i]     = ax + dx * rnd_coord(3);
                        c[2 * i + 1] = ay + dy * rnd_coord(3);
                    end
                    c[0] = ax + dx * rnd_coord(4);
                    c[1] = ay + dy * rnd_coord(4) + ($urandom_range(3) == 0);
                end
                1: begin
                    // q on a hull point
                    ax = $urandom_range(4, 1);
                    c[0] = c[2 * ax];
                    c[1] = c[2 * ax + 1];
                end
                2: begin
                    // q at the midpoint of a pair with even spacing
                    ax = $urandom_range(4, 1);
                    dx = $urandom_range(4, 1);
                    c[2 * dx]     = c[2 * ax] + 2 * rnd_coord(4);
                    c[2 * dx + 1] = c[2 * ax + 1] + 2 * rnd_coord(4);
                    c[0] = (c[2 * ax] + c[2 * dx]) / 2;
                    c[1] = (c[2 * ax + 1] + c[2 * dx + 1]) / 2;
                end
                default: ;
            endcase
            send_coords(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9]);
        end
    endtask

    task automatic test_output_hold_off();
        hold_request = 1'b1;
        test_random_sets(40);
    endtask

    task automatic test_back_to_back();
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        test_random_sets(60);
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        item_taken    = 1'b0;
        mismatch_cnt  = 0;
        cycle_cnt     = 0;
        hold_request  = 1'b0;
        hold_left     = 0;
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_sets(200);
        test_output_hold_off();
        test_back_to_back();
        test_random_sets(100);

        s_tvalid <= 1'b0;
        while (expected_class_q.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (mismatch_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
